>>> hw/rtl/npcm_pkg.sv
`timescale 1ns / 1ps

package npcm_pkg;

    // Port widths of the request and result fields
    localparam int IDX_PORT_W  = 8;
    localparam int CHAN_PORT_W = 8;
    localparam int DIST_PORT_W = 10;
    localparam int CNT_W       = 9;

    // One result as it sits in the output buffer
    localparam int RES_W = IDX_PORT_W + 3 * CHAN_PORT_W + DIST_PORT_W;

    // Defaults for the top-level parameters
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int CHANNEL_BITS_DEF  = 8;

    // Palette count after reset
    localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // Control bits that travel with each token along the chain
    typedef struct packed {
        logic valid;
        logic is_map;
        logic found;
    } t_ctl;

endpackage

>>> hw/rtl/npcm_cell.sv
`timescale 1ns / 1ps

// One palette entry plus one pipeline stage of the search chain.
module npcm_cell #(
    parameter int CELL_INDEX   = 0,
    parameter int IDX_W        = 8,
    parameter int CHANNEL_BITS = npcm_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [npcm_pkg::CNT_W-1:0]          i_count,
    input  npcm_pkg::t_ctl                      i_ctl,
    input  logic [npcm_pkg::IDX_PORT_W-1:0]     i_entry_index,
    input  logic [2:0][CHANNEL_BITS-1:0]        i_pix,
    input  logic [IDX_W-1:0]                    i_best_idx,
    input  logic [2:0][CHANNEL_BITS-1:0]        i_best_col,
    input  logic [CHANNEL_BITS+1:0]             i_best_dist,
    output npcm_pkg::t_ctl                      o_ctl,
    output logic [npcm_pkg::IDX_PORT_W-1:0]     o_entry_index,
    output logic [2:0][CHANNEL_BITS-1:0]        o_pix,
    output logic [IDX_W-1:0]                    o_best_idx,
    output logic [2:0][CHANNEL_BITS-1:0]        o_best_col,
    output logic [CHANNEL_BITS+1:0]             o_best_dist
);

    localparam int DIST_W = CHANNEL_BITS + 2;
    localparam int CMP_W  = (IDX_W > npcm_pkg::CNT_W) ? IDX_W + 1 : npcm_pkg::CNT_W + 1;
    localparam int EIX_W  = (IDX_W > npcm_pkg::IDX_PORT_W) ? IDX_W : npcm_pkg::IDX_PORT_W;
    localparam logic [CMP_W-1:0] CELL_CMP = CMP_W'(CELL_INDEX);
    localparam logic [EIX_W-1:0] CELL_EIX = EIX_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);

    logic [2:0][CHANNEL_BITS-1:0] r_entry;
    npcm_pkg::t_ctl               r_ctl;
    npcm_pkg::t_ctl               n_ctl;
    logic [npcm_pkg::IDX_PORT_W-1:0] r_entry_index;
    logic [2:0][CHANNEL_BITS-1:0] r_pix;
    logic [IDX_W-1:0]             r_best_idx;
    logic [IDX_W-1:0]             n_best_idx;
    logic [2:0][CHANNEL_BITS-1:0] r_best_col;
    logic [2:0][CHANNEL_BITS-1:0] n_best_col;
    logic [DIST_W-1:0]            r_best_dist;
    logic [DIST_W-1:0]            n_best_dist;
    logic [DIST_W-1:0]            w_dist;
    logic                         w_active;
    logic                         w_take;
    logic                         w_load;

    // Manhattan distance from the passing pixel to this entry
    always_comb begin
        logic [CHANNEL_BITS-1:0] diff;
        w_dist = '0;
        for (int c = 0; c < 3; c++) begin
            if (i_pix[c] > r_entry[c]) begin
                diff = i_pix[c] - r_entry[c];
            end else begin
                diff = r_entry[c] - i_pix[c];
            end
            w_dist = w_dist + DIST_W'(diff);
        end
    end

    // Entry takes part only below the palette count; strict compare keeps lowest index on ties
    assign w_active = CELL_CMP < CMP_W'(i_count);
    assign w_take   = i_ctl.valid && i_ctl.is_map && w_active &&
                      (!i_ctl.found || (w_dist < i_best_dist));
    assign w_load   = i_adv && i_ctl.valid && !i_ctl.is_map &&
                      (EIX_W'(i_entry_index) == CELL_EIX);

    always_comb begin
        n_ctl       = i_ctl;
        n_ctl.found = i_ctl.found | w_take;
        n_best_idx  = w_take ? CELL_IDX : i_best_idx;
        n_best_col  = w_take ? r_entry  : i_best_col;
        n_best_dist = w_take ? w_dist   : i_best_dist;
    end

    // Palette entry, written when a load token for this index passes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry <= i_pix;
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_entry_index <= i_entry_index;
            r_pix         <= i_pix;
            r_best_idx    <= n_best_idx;
            r_best_col    <= n_best_col;
            r_best_dist   <= n_best_dist;
        end
    end

    assign o_ctl         = r_ctl;
    assign o_entry_index = r_entry_index;
    assign o_pix         = r_pix;
    assign o_best_idx    = r_best_idx;
    assign o_best_col    = r_best_col;
    assign o_best_dist   = r_best_dist;

endmodule

>>> hw/rtl/npcm_out_buf.sv
`timescale 1ns / 1ps

// Two-entry result buffer between the chain and the output channel.
module npcm_out_buf #(
    parameter int WIDTH = npcm_pkg::RES_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_pop;

    assign w_pop   = (r_count != 2'd0) && i_ready;
    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/nearest_palette_color_mapper.sv
`timescale 1ns / 1ps

// Nearest palette colour mapper.
// Input channel (i_in_valid / o_in_ready): a load request (req_type 0) writes
// one palette entry and gives no result; a map request (req_type 1) carries a
// pixel and gives one result: index, colour and Manhattan distance of the
// closest entry among the first palette_count entries, lowest index on ties.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): writes palette_count;
// the user must do so only while no request is in flight, unchecked by the block.
// Every request walks a chain of PALETTE_DEPTH cells, one cell per cycle while
// the chain is not frozen, each cell holding one entry, so loads and maps keep
// their order exactly.
// Throughput: one request per cycle while the result buffer has room.
// Output stall: results collect in a two-entry buffer; once it is full the
// whole chain freezes and o_in_ready drops until the receiver takes one.
// Reset: palette_count returns to 256, chain and buffer empty; palette
// contents are undefined until loaded.
module nearest_palette_color_mapper #(
    parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF,
    parameter int CHANNEL_BITS  = npcm_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [npcm_pkg::CNT_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [npcm_pkg::IDX_PORT_W-1:0]     i_entry_index,
    input  logic [npcm_pkg::CHAN_PORT_W-1:0]    i_chan_first,
    input  logic [npcm_pkg::CHAN_PORT_W-1:0]    i_chan_second,
    input  logic [npcm_pkg::CHAN_PORT_W-1:0]    i_chan_third,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [npcm_pkg::IDX_PORT_W-1:0]     o_nearest_index,
    output logic [npcm_pkg::CHAN_PORT_W-1:0]    o_out_first,
    output logic [npcm_pkg::CHAN_PORT_W-1:0]    o_out_second,
    output logic [npcm_pkg::CHAN_PORT_W-1:0]    o_out_third,
    output logic [npcm_pkg::DIST_PORT_W-1:0]    o_best_distance
);

    localparam int IDX_W  = $clog2(PALETTE_DEPTH);
    localparam int DIST_W = CHANNEL_BITS + 2;
    localparam int IW     = npcm_pkg::IDX_PORT_W;
    localparam int CW     = npcm_pkg::CHAN_PORT_W;
    localparam int DW     = npcm_pkg::DIST_PORT_W;
    localparam int RW     = npcm_pkg::RES_W;

    logic [npcm_pkg::CNT_W-1:0] r_palette_count;
    logic                       w_adv;
    logic                       w_buf_full;
    logic                       w_push;
    logic [RW-1:0]              w_res;
    logic [RW-1:0]              w_out_data;

    npcm_pkg::t_ctl                    w_ctl        [0:PALETTE_DEPTH];
    logic [IW-1:0]                     w_entry_idx  [0:PALETTE_DEPTH];
    logic [2:0][CHANNEL_BITS-1:0]      w_pix        [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]                  w_best_idx   [0:PALETTE_DEPTH];
    logic [2:0][CHANNEL_BITS-1:0]      w_best_col   [0:PALETTE_DEPTH];
    logic [DIST_W-1:0]                 w_best_dist  [0:PALETTE_DEPTH];

    // Palette count register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= npcm_pkg::CNT_RESET;
        end else if (i_cfg_valid) begin
            r_palette_count <= i_cfg_data;
        end
    end

    // Chain moves whenever the result buffer has room
    assign w_adv      = !w_buf_full;
    assign o_in_ready = w_adv;

    // Head of the chain: fresh token, nothing found yet
    assign w_ctl[0]       = {i_in_valid, i_req_type == npcm_pkg::REQ_MAP, 1'b0};
    assign w_entry_idx[0] = i_entry_index;
    assign w_pix[0]       = {CHANNEL_BITS'(i_chan_third),
                             CHANNEL_BITS'(i_chan_second),
                             CHANNEL_BITS'(i_chan_first)};
    assign w_best_idx[0]  = '0;
    assign w_best_col[0]  = '0;
    assign w_best_dist[0] = '0;

    // Row of cells, one per palette entry
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npcm_cell #(
            .CELL_INDEX   (g),
            .IDX_W        (IDX_W),
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_adv         (w_adv),
            .i_count       (r_palette_count),
            .i_ctl         (w_ctl[g]),
            .i_entry_index (w_entry_idx[g]),
            .i_pix         (w_pix[g]),
            .i_best_idx    (w_best_idx[g]),
            .i_best_col    (w_best_col[g]),
            .i_best_dist   (w_best_dist[g]),
            .o_ctl         (w_ctl[g+1]),
            .o_entry_index (w_entry_idx[g+1]),
            .o_pix         (w_pix[g+1]),
            .o_best_idx    (w_best_idx[g+1]),
            .o_best_col    (w_best_col[g+1]),
            .o_best_dist   (w_best_dist[g+1])
        );
    end

    // Tail: map tokens become results, load tokens drop out; empty search gives zeros
    assign w_push = w_adv && w_ctl[PALETTE_DEPTH].valid && w_ctl[PALETTE_DEPTH].is_map;

    always_comb begin
        if (w_ctl[PALETTE_DEPTH].found) begin
            w_res = {IW'(w_best_idx[PALETTE_DEPTH]),
                     CW'(w_best_col[PALETTE_DEPTH][0]),
                     CW'(w_best_col[PALETTE_DEPTH][1]),
                     CW'(w_best_col[PALETTE_DEPTH][2]),
                     DW'(w_best_dist[PALETTE_DEPTH])};
        end else begin
            w_res = '0;
        end
    end

    npcm_out_buf #(
        .WIDTH (RW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out_data)
    );

    assign o_nearest_index = w_out_data[RW-1 -: IW];
    assign o_out_first     = w_out_data[RW-IW-1 -: CW];
    assign o_out_second    = w_out_data[RW-IW-CW-1 -: CW];
    assign o_out_third     = w_out_data[RW-IW-2*CW-1 -: CW];
    assign o_best_distance = w_out_data[DW-1:0];

endmodule
